@@ hdl/tlsa_pkg.sv @@
// Shared types, constants and per-entry functions of the three-level scheduler.
// Used by tlsa_cell and three_level_scheduler_with_aging; no dependencies.
`default_nettype none
package tlsa_pkg;

  localparam int THREADS   = 16;
  localparam int TID_W     = 4;
  localparam int PRIO_W    = 8;
  localparam int TICK_W    = 32;
  localparam int ORD_W     = 16;
  localparam int QNT_W     = 16;
  localparam int CNT_W     = $clog2(THREADS);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  typedef enum logic [1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_AGE = 2'd2,
    CMD_RET = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_DUP   = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_L1_TH   = 3'd0,
    REG_L2_TH   = 3'd1,
    REG_MAX_PRI = 3'd2,
    REG_QUANTUM = 3'd3,
    REG_STEP    = 3'd4
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_1    = 2'd1;
  localparam logic [1:0] LVL_2    = 2'd2;
  localparam logic [1:0] LVL_3    = 2'd3;

  // One thread's slot as it travels round the ring
  typedef struct packed {
    logic [TID_W-1:0]  id;
    logic              queued;
    logic              pend2;   // promotion 2 -> 1 awaiting its stamp
    logic              pend3;   // promotion 3 -> 2 awaiting its stamp
    logic [1:0]        level;
    logic [PRIO_W-1:0] prio;
    logic [TICK_W-1:0] burst;
    logic [TICK_W-1:0] token;
    logic [TICK_W-1:0] since;
    logic [ORD_W-1:0]  order;
  } entry_t;

  // Configuration register set
  typedef struct packed {
    logic [PRIO_W-1:0] l1_th;
    logic [PRIO_W-1:0] l2_th;
    logic [PRIO_W-1:0] max_pri;
    logic [QNT_W-1:0]  quantum;
    logic [PRIO_W-1:0] step;
  } cfg_t;

  // Older arrival first, lower id on equal age
  function automatic logic ordered_before(entry_t c, entry_t b, logic [ORD_W-1:0] cnt);
    logic [ORD_W-1:0] ac;
    logic [ORD_W-1:0] ab;
    ac = cnt - c.order;
    ab = cnt - b.order;
    return (ac > ab) || ((ac == ab) && (c.id < b.id));
  endfunction

  // Dequeue preference: lowest level, then the level's own key
  function automatic logic deq_better(entry_t c, entry_t b, logic [ORD_W-1:0] cnt);
    logic res;
    if (c.level != b.level) begin
      res = c.level < b.level;
    end else begin
      case (c.level)
        LVL_1: res = (c.burst < b.burst) ||
                     ((c.burst == b.burst) && ordered_before(c, b, cnt));
        LVL_2: res = (c.prio > b.prio) ||
                     ((c.prio == b.prio) && ordered_before(c, b, cnt));
        default: res = ordered_before(c, b, cnt);
      endcase
    end
    return res;
  endfunction

  // Stamp order: level 2 promotions before level 3, each oldest first
  function automatic logic pend_better(entry_t c, entry_t b, logic [ORD_W-1:0] cnt);
    logic res;
    if (c.pend2 != b.pend2) begin
      res = c.pend2;
    end else begin
      res = ordered_before(c, b, cnt);
    end
    return res;
  endfunction

  // Token accrual, quantum exchange and promotion check for one entry
  function automatic entry_t age_one(entry_t e, logic [TICK_W-1:0] now, cfg_t cfg);
    entry_t            r;
    logic [TICK_W-1:0] elapsed;
    logic [TICK_W:0]   sum;
    logic [TICK_W-1:0] tok;
    logic [PRIO_W:0]   p;
    r       = e;
    elapsed = now - e.since;
    sum     = {1'b0, e.token} + {1'b0, elapsed};
    tok     = sum[TICK_W] ? '1 : sum[TICK_W-1:0];
    r.since = now;
    if (e.prio < cfg.max_pri) begin
      p = {1'b0, e.prio};
      if (tok >= {{(TICK_W-QNT_W){1'b0}}, cfg.quantum}) begin
        tok = tok - {{(TICK_W-QNT_W){1'b0}}, cfg.quantum};
        p   = p + {1'b0, cfg.step};
      end
      if (p > {1'b0, cfg.max_pri}) begin
        p = {1'b0, cfg.max_pri};
      end
      r.prio = p[PRIO_W-1:0];
    end
    r.token = tok;
    r.pend3 = (e.level == LVL_3) && (r.prio >= cfg.l2_th);
    r.pend2 = (e.level == LVL_2) && (r.prio >= cfg.l1_th);
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/three_level_scheduler_with_aging.sv @@
// Three-level ready-queue scheduler with aging: ring of thread cells plus controller.
// Depends on tlsa_pkg and tlsa_cell.
//
// Usage: one command item enters on the in channel (valid/ready) and yields
// exactly one result item on the out channel (valid/ready). The thread
// entries live in a ring of 16 cells that rotates once per pass; the head
// cell is read, updated and written back at the tail each cycle of a scan.
// Enqueue, retire and a dequeue that finds nothing take one pass of the ring, a
// dequeue that takes a thread takes two, and an aging pass takes one plus one per
// promoted thread; the result is then loaded in the FIN state.
// A new item is taken only when the controller is idle, which it is again in the
// cycle after the result is loaded.
// A finished result sits in the output register; a stalled receiver holds the next
// result back at the end of its pass, and no new item is taken in meanwhile.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i; the user
// must write it only while idle, the block itself does not enforce this.
// Reset empties every queue, clears tokens, restores the register defaults
// (thresholds 100 and 50, ceiling 149, quantum 1500, step 10).
`default_nettype none
module three_level_scheduler_with_aging (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    cmd_i,
  input  wire logic [tlsa_pkg::TID_W-1:0]    thread_id_i,
  input  wire logic [tlsa_pkg::PRIO_W-1:0]   priority_req_i,
  input  wire logic [tlsa_pkg::TICK_W-1:0]   burst_estimate_i,
  input  wire logic [tlsa_pkg::TICK_W-1:0]   now_tick_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         status_o,
  output logic [tlsa_pkg::TID_W-1:0]         chosen_id_o,
  output logic [tlsa_pkg::PRIO_W-1:0]        chosen_priority_o,
  output logic [1:0]                         chosen_level_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [tlsa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [tlsa_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam logic [tlsa_pkg::CNT_W-1:0] LAST = tlsa_pkg::CNT_W'(tlsa_pkg::THREADS - 1);

  tlsa_pkg::entry_t ring [tlsa_pkg::THREADS];
  tlsa_pkg::entry_t head_d;
  tlsa_pkg::entry_t aged;
  tlsa_pkg::entry_t best_q, best_d;
  tlsa_pkg::cfg_t   cfg_q;
  tlsa_pkg::state_e state_q, state_d;
  tlsa_pkg::cmd_e   op_q;

  logic                          scan;
  logic [tlsa_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                          ph_q, ph_d;
  logic                          bvld_q, bvld_d;
  logic [tlsa_pkg::ORD_W-1:0]    ctr_q, ctr_d;
  logic [tlsa_pkg::ORD_W-1:0]    ref_q, ref_d;
  logic [tlsa_pkg::TID_W-1:0]    sel_q, sel_d;
  logic [tlsa_pkg::TID_W-1:0]    tid_q;
  logic [tlsa_pkg::PRIO_W-1:0]   prio_q;
  logic [tlsa_pkg::TICK_W-1:0]   burst_q;
  logic [tlsa_pkg::TICK_W-1:0]   now_q;
  logic                          elig;
  logic                          better;
  logic [1:0]                    rsts_q, rsts_d;
  logic [tlsa_pkg::TID_W-1:0]    rid_q, rid_d;
  logic [tlsa_pkg::PRIO_W-1:0]   rpri_q, rpri_d;
  logic [1:0]                    rlvl_q, rlvl_d;
  logic                          ovld_q, ovld_d;
  logic                          accept;
  logic                          load_out;
  logic [tlsa_pkg::THREADS-1:0]  id_hit;

  // Ring of cells; tail takes the updated head
  for (genvar k = 0; k < tlsa_pkg::THREADS; k++) begin : g_ring
    if (k == tlsa_pkg::THREADS - 1) begin : g_tail
      tlsa_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .shift_i  (scan),
        .rst_id_i (tlsa_pkg::TID_W'(k)),
        .ent_i    (head_d),
        .ent_o    (ring[k])
      );
    end else begin : g_body
      tlsa_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .shift_i  (scan),
        .rst_id_i (tlsa_pkg::TID_W'(k)),
        .ent_i    (ring[k+1]),
        .ent_o    (ring[k])
      );
    end
    assign id_hit[k] = (ring[k].id == tid_q);
  end

  assign scan       = (state_q == tlsa_pkg::ST_SCAN);
  assign in_ready_o = (state_q == tlsa_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign aged       = tlsa_pkg::age_one(ring[0], now_q, cfg_q);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.l1_th   <= 8'd100;
      cfg_q.l2_th   <= 8'd50;
      cfg_q.max_pri <= 8'd149;
      cfg_q.quantum <= 16'd1500;
      cfg_q.step    <= 8'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tlsa_pkg::REG_L1_TH:   cfg_q.l1_th   <= cfg_data_i[tlsa_pkg::PRIO_W-1:0];
        tlsa_pkg::REG_L2_TH:   cfg_q.l2_th   <= cfg_data_i[tlsa_pkg::PRIO_W-1:0];
        tlsa_pkg::REG_MAX_PRI: cfg_q.max_pri <= cfg_data_i[tlsa_pkg::PRIO_W-1:0];
        tlsa_pkg::REG_QUANTUM: cfg_q.quantum <= cfg_data_i[tlsa_pkg::QNT_W-1:0];
        tlsa_pkg::REG_STEP:    cfg_q.step    <= cfg_data_i[tlsa_pkg::PRIO_W-1:0];
        default: ;
      endcase
    end
  end

  // Command item capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= tlsa_pkg::cmd_e'(cmd_i);
      tid_q   <= thread_id_i;
      prio_q  <= priority_req_i;
      burst_q <= burst_estimate_i;
      now_q   <= now_tick_i;
    end
  end

  // Controller state and scan registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlsa_pkg::ST_IDLE;
      cnt_q   <= '0;
      ph_q    <= 1'b0;
      bvld_q  <= 1'b0;
      ctr_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ph_q    <= ph_d;
      bvld_q  <= bvld_d;
      ctr_q   <= ctr_d;
      ovld_q  <= ovld_d;
    end
  end

  // Scan payload and result registers
  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    ref_q  <= ref_d;
    sel_q  <= sel_d;
    rsts_q <= rsts_d;
    rid_q  <= rid_d;
    rpri_q <= rpri_d;
    rlvl_q <= rlvl_d;
    if (load_out) begin
      status_o          <= rsts_q;
      chosen_id_o       <= rid_q;
      chosen_priority_o <= rpri_q;
      chosen_level_o    <= rlvl_q;
    end
  end

  assign out_valid_o = ovld_q;

  // Head update, best-candidate search and sequencing
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ph_d     = ph_q;
    bvld_d   = bvld_q;
    ctr_d    = ctr_q;
    ref_d    = ref_q;
    sel_d    = sel_q;
    best_d   = best_q;
    rsts_d   = rsts_q;
    rid_d    = rid_q;
    rpri_d   = rpri_q;
    rlvl_d   = rlvl_q;
    head_d   = ring[0];
    elig     = 1'b0;
    better   = 1'b0;
    load_out = 1'b0;
    ovld_d   = ovld_q && !out_ready_i;

    case (state_q)
      tlsa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = tlsa_pkg::ST_SCAN;
          cnt_d   = '0;
          ph_d    = 1'b0;
          bvld_d  = 1'b0;
          ref_d   = ctr_q;
          rsts_d  = tlsa_pkg::STS_OK;
          rid_d   = '0;
          rpri_d  = '0;
          rlvl_d  = tlsa_pkg::LVL_NONE;
        end
      end

      tlsa_pkg::ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        case (op_q)
          tlsa_pkg::CMD_ENQ: begin
            if (ring[0].id == tid_q) begin
              if (ring[0].queued) begin
                rsts_d = tlsa_pkg::STS_DUP;
              end else begin
                head_d.queued = 1'b1;
                head_d.pend2  = 1'b0;
                head_d.pend3  = 1'b0;
                head_d.level  = (prio_q >= cfg_q.l1_th) ? tlsa_pkg::LVL_1 :
                                (prio_q >= cfg_q.l2_th) ? tlsa_pkg::LVL_2 :
                                                          tlsa_pkg::LVL_3;
                head_d.prio   = prio_q;
                head_d.burst  = burst_q;
                head_d.since  = now_q;
                head_d.order  = ctr_q;
                ctr_d         = ctr_q + 1'b1;
              end
            end
          end
          tlsa_pkg::CMD_RET: begin
            if (ring[0].id == tid_q) begin
              head_d.token = '0;
            end
          end
          tlsa_pkg::CMD_DEQ: begin
            if (!ph_q) begin
              elig   = ring[0].queued;
              better = tlsa_pkg::deq_better(ring[0], best_q, ref_q);
            end else if (ring[0].id == sel_q) begin
              head_d.queued = 1'b0;
            end
          end
          tlsa_pkg::CMD_AGE: begin
            if (!ph_q) begin
              if (ring[0].queued) begin
                head_d = aged;
              end
            end else if (ring[0].id == sel_q) begin
              // promotion takes the next arrival stamp
              head_d.level = ring[0].level - 1'b1;
              head_d.order = ctr_q;
              head_d.pend2 = 1'b0;
              head_d.pend3 = 1'b0;
              ctr_d        = ctr_q + 1'b1;
            end
            elig   = head_d.pend2 || head_d.pend3;
            better = tlsa_pkg::pend_better(head_d, best_q, ref_q);
          end
          default: ;
        endcase

        if (elig && (!bvld_q || better)) begin
          best_d = head_d;
          bvld_d = 1'b1;
        end

        // End of one rotation
        if (cnt_q == LAST) begin
          cnt_d = '0;
          case (op_q)
            tlsa_pkg::CMD_DEQ: begin
              if (ph_q) begin
                state_d = tlsa_pkg::ST_FIN;
              end else if (bvld_d) begin
                sel_d  = best_d.id;
                rid_d  = best_d.id;
                rpri_d = best_d.prio;
                rlvl_d = best_d.level;
                ph_d   = 1'b1;
                bvld_d = 1'b0;
              end else begin
                rsts_d  = tlsa_pkg::STS_EMPTY;
                state_d = tlsa_pkg::ST_FIN;
              end
            end
            tlsa_pkg::CMD_AGE: begin
              if (bvld_d) begin
                sel_d  = best_d.id;
                ph_d   = 1'b1;
                bvld_d = 1'b0;
                ref_d  = ctr_d + 1'b1;
              end else begin
                state_d = tlsa_pkg::ST_FIN;
              end
            end
            default: state_d = tlsa_pkg::ST_FIN;
          endcase
        end
      end

      tlsa_pkg::ST_FIN: begin
        if (!ovld_q || out_ready_i) begin
          load_out = 1'b1;
          ovld_d   = 1'b1;
          state_d  = tlsa_pkg::ST_IDLE;
        end
      end

      default: state_d = tlsa_pkg::ST_IDLE;
    endcase
  end

  // The commanded thread id is held by exactly one ring cell during a scan
  a_ids_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tlsa_pkg::ST_SCAN) |-> $onehot(id_hit))
    else $error("ring holds duplicate or missing thread id");

  // Arrival counter advances by at most one per cycle
  a_ctr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctr_q == $past(ctr_q)) || (ctr_q == $past(ctr_q) + 1'b1))
    else $error("arrival counter jumped");

  // Only a successful dequeue reports a thread
  a_res_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != tlsa_pkg::STS_OK)) |->
    ((chosen_id_o == '0) && (chosen_level_o == tlsa_pkg::LVL_NONE)))
    else $error("failed command reports a thread");

  // A valid dequeue result names a real level
  a_res_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && (op_q == tlsa_pkg::CMD_DEQ) && (rsts_q == tlsa_pkg::STS_OK)) |=>
    (chosen_level_o != tlsa_pkg::LVL_NONE))
    else $error("dequeue result without level");

endmodule
`default_nettype wire

@@ hdl/tlsa_cell.sv @@
// One slot of the scheduler ring: holds a thread's entry, passes it on when shifting.
// Depends on tlsa_pkg.
`default_nettype none
module tlsa_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      shift_i,
  input  wire logic [tlsa_pkg::TID_W-1:0] rst_id_i,
  input  wire tlsa_pkg::entry_t           ent_i,
  output tlsa_pkg::entry_t                ent_o
);

  tlsa_pkg::entry_t ent_q;

  // Whole entry; id comes from the slot position at reset, payload is only read while queued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q.id     <= rst_id_i;
      ent_q.queued <= 1'b0;
      ent_q.pend2  <= 1'b0;
      ent_q.pend3  <= 1'b0;
      ent_q.level  <= '0;
      ent_q.prio   <= '0;
      ent_q.burst  <= '0;
      ent_q.token  <= '0;
      ent_q.since  <= '0;
      ent_q.order  <= '0;
    end else if (shift_i) begin
      ent_q <= ent_i;
    end
  end

  assign ent_o = ent_q;

endmodule
`default_nettype wire
